### rtl/core/antenna_pattern_gain_eval_macros.svh
// assertion macros for the antenna pattern gain evaluator
// used by the top level, which must provide aclk and aresetn
`ifndef ANTENNA_PATTERN_GAIN_EVAL_MACROS_SVH
`define ANTENNA_PATTERN_GAIN_EVAL_MACROS_SVH

// same-cycle implication, disabled while in reset
`define APG_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define APG_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/apg_pkg.sv
// shared types, constants and tables for the antenna pattern gain evaluator
// no dependencies
package apg_pkg;

    // vector component width taken from each field
    localparam int VECTOR_WIDTH = 32;

    // register map
    localparam int REG_IDX_W = 3;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_BS_X  = 3'd0,
        REG_BS_Y  = 3'd1,
        REG_BS_Z  = 3'd2,
        REG_PEAK  = 3'd3,
        REG_BW    = 3'd4,
        REG_SIDE  = 3'd5,
        REG_BACK  = 3'd6
    } reg_idx_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_PATTERN = 2'd1,
        ST_ZERO_LOOK   = 2'd2
    } status_t;

    // register reset values
    localparam logic signed [15:0] PEAK_RESET = 16'sd0;
    localparam logic [15:0]        BW_RESET   = 16'd2560;
    localparam logic signed [15:0] SIDE_RESET = -16'sd5120;
    localparam logic signed [15:0] BACK_RESET = -16'sd7680;

    // pattern limits, degrees and dB in Q8.8
    localparam logic [15:0]        ANGLE_MAX    = 16'd46080;
    localparam logic [15:0]        DEG90_Q8     = 16'd23040;
    localparam logic signed [15:0] SIDELOBE_MAX = -16'sd768;

    // pipeline geometry
    localparam int FRONT_STAGES = 6;
    localparam int SQRT_STAGES  = 32;
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int DIV_STAGES   = 10;
    localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + CORDIC_LAT + 2 + DIV_STAGES;

    // cordic datapath widths
    localparam int CORDIC_W  = 36;
    localparam int ANG_ACC_W = 26;
    localparam logic signed [ANG_ACC_W-1:0] DEG90_Q16 = 26'sd5898240;

    // arctangent of 2^-i in degrees Q16.16
    localparam logic signed [ANG_ACC_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
        26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
        26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
    };

    // dot product travelling beside the square root
    typedef logic signed [32:0] dot_t;

    // per-stage control
    typedef struct packed {
        logic vld;
        logic zero;
    } ctl_t;

    typedef struct packed {
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
    } in_t;

    typedef struct packed {
        logic signed [16:0] gain_q8;
        logic [15:0]        off_axis_angle;
        status_t            status;
    } out_t;

endpackage

### rtl/core/apg_isqrt.sv
// pipelined floor square root of a 64-bit value, one result bit per stage
// depends on apg_pkg; carries the dot product alongside
module apg_isqrt (
    input  logic          aclk,
    input  logic          en,
    input  logic [63:0]   rad,
    input  apg_pkg::dot_t dot_in,
    output logic [31:0]   root,
    output apg_pkg::dot_t dot_out
);
    import apg_pkg::*;

    logic [63:0] rem_reg  [SQRT_STAGES];
    logic [31:0] root_reg [SQRT_STAGES];
    dot_t        dot_reg  [SQRT_STAGES];

    logic [63:0] rem_in  [SQRT_STAGES];
    logic [31:0] root_in [SQRT_STAGES];
    dot_t        dot_in_s [SQRT_STAGES];

    // stage inputs
    assign rem_in[0]   = rad;
    assign root_in[0]  = '0;
    assign dot_in_s[0] = dot_in;
    for (genvar k = 1; k < SQRT_STAGES; k++) begin : g_link
        assign rem_in[k]   = rem_reg[k-1];
        assign root_in[k]  = root_reg[k-1];
        assign dot_in_s[k] = dot_reg[k-1];
    end

    // stage k decides bit 31-k: test (root << (i+1)) | (1 << 2i) against remainder
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam int BIT = SQRT_STAGES - 1 - k;
        logic [64:0] trial;
        assign trial = (65'(root_in[k]) << (BIT + 1)) | (65'(1) << (2 * BIT));
        always_ff @(posedge aclk) begin
            if (en) begin
                dot_reg[k] <= dot_in_s[k];
                if (65'(rem_in[k]) >= trial) begin
                    rem_reg[k]  <= 64'(65'(rem_in[k]) - trial);
                    root_reg[k] <= root_in[k] | (32'(1) << BIT);
                end else begin
                    rem_reg[k]  <= rem_in[k];
                    root_reg[k] <= root_in[k];
                end
            end
        end
    end

    assign root    = root_reg[SQRT_STAGES-1];
    assign dot_out = dot_reg[SQRT_STAGES-1];

endmodule

### rtl/core/apg_cordic.sv
// pipelined cordic vectoring: angle of (dot, cross magnitude) in degrees Q8.8
// depends on apg_pkg; pre-rotation stage, one stage per step, one rounding stage
module apg_cordic (
    input  logic          aclk,
    input  logic          en,
    input  apg_pkg::dot_t dot,
    input  logic [31:0]   cmag,
    output logic [15:0]   angle
);
    import apg_pkg::*;

    typedef struct packed {
        logic signed [CORDIC_W-1:0]  x;
        logic signed [CORDIC_W-1:0]  y;
        logic signed [ANG_ACC_W-1:0] z;
    } cst_t;

    cst_t        cst_reg [CORDIC_STEPS+1];
    logic [15:0] angle_reg;

    logic signed [CORDIC_W-1:0] x0, y0;
    assign x0 = CORDIC_W'(dot);
    assign y0 = CORDIC_W'({1'b0, cmag});

    // pre-rotation by -90 degrees when the dot product is negative
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dot < 0) begin
                cst_reg[0].x <= y0;
                cst_reg[0].y <= -x0;
                cst_reg[0].z <= DEG90_Q16;
            end else begin
                cst_reg[0].x <= x0;
                cst_reg[0].y <= y0;
                cst_reg[0].z <= '0;
            end
        end
    end

    // micro-rotations, driving y toward zero
    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_step
        localparam int SH = k - 1;
        logic signed [CORDIC_W-1:0] xs, ys;
        assign xs = cst_reg[k-1].x >>> SH;
        assign ys = cst_reg[k-1].y >>> SH;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (cst_reg[k-1].y >= 0) begin
                    cst_reg[k].x <= cst_reg[k-1].x + ys;
                    cst_reg[k].y <= cst_reg[k-1].y - xs;
                    cst_reg[k].z <= cst_reg[k-1].z + ATAN_Q16[SH];
                end else begin
                    cst_reg[k].x <= cst_reg[k-1].x - ys;
                    cst_reg[k].y <= cst_reg[k-1].y + xs;
                    cst_reg[k].z <= cst_reg[k-1].z - ATAN_Q16[SH];
                end
            end
        end
    end

    // clamp at zero, round to Q8.8, clamp at the top of range
    logic [ANG_ACC_W-1:0] zpos;
    logic [ANG_ACC_W-1:0] zrnd;
    logic [ANG_ACC_W-9:0] zq;
    assign zpos = (cst_reg[CORDIC_STEPS].z < 0) ? '0 : cst_reg[CORDIC_STEPS].z;
    assign zrnd = zpos + ANG_ACC_W'(128);
    assign zq   = zrnd[ANG_ACC_W-1:8];

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= (zq > (ANG_ACC_W-8)'(ANGLE_MAX)) ? ANGLE_MAX : zq[15:0];
        end
    end

    assign angle = angle_reg;

endmodule

### rtl/core/antenna_pattern_gain_eval.sv
// Antenna pattern gain evaluator. Takes one look vector per cycle while not stalled and
// returns the off-axis angle from the configured boresight and the gain in that direction
// (main lobe, sidelobe plateau or backlobe plateau). The pipeline holds the 32-stage square
// root, the 22-stage cordic and the 10-stage divider. The whole pipeline advances together
// and freezes while the output register holds an untaken item.
// Configuration writes are registered and must only be made while idle.
// Depends on apg_pkg, apg_isqrt, apg_cordic and the assertion macro header.
`include "antenna_pattern_gain_eval_macros.svh"

module antenna_pattern_gain_eval (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  apg_pkg::in_t                    s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output apg_pkg::out_t                   m_item,
    input  logic                            cfg_wr_en,
    input  logic [apg_pkg::REG_IDX_W-1:0]   cfg_idx,
    input  logic [31:0]                     cfg_wdata
);
    import apg_pkg::*;

    // helpers for vector prescaling
    function automatic logic [31:0] mag_of(input logic [31:0] v);
        logic signed [31:0] sx;
        sx = 32'(signed'(v[VECTOR_WIDTH-1:0]));
        return sx[31] ? 32'(-sx) : 32'(sx);
    endfunction

    function automatic logic [4:0] shift_of(input logic [31:0] m);
        logic [4:0] s;
        s = '0;
        for (int i = 15; i < 32; i++) begin
            if (m[i]) s = 5'(i - 14);
        end
        return s;
    endfunction

    function automatic logic signed [15:0] scale_of(input logic [31:0] m, input logic neg,
                                                    input logic [4:0] s);
        logic signed [15:0] v;
        v = 16'(m >> s);
        return neg ? -v : v;
    endfunction

    function automatic logic [31:0] max3(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
        logic [31:0] ab;
        ab = (a > b) ? a : b;
        return (ab > c) ? ab : c;
    endfunction

    // configuration registers
    logic signed [31:0] bsx_reg, bsy_reg, bsz_reg;
    logic signed [15:0] peak_reg, side_reg, back_reg;
    logic [15:0]        bw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsx_reg  <= 32'sd1;
            bsy_reg  <= '0;
            bsz_reg  <= '0;
            peak_reg <= PEAK_RESET;
            bw_reg   <= BW_RESET;
            side_reg <= SIDE_RESET;
            back_reg <= BACK_RESET;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_idx))
                REG_BS_X: bsx_reg  <= cfg_wdata;
                REG_BS_Y: bsy_reg  <= cfg_wdata;
                REG_BS_Z: bsz_reg  <= cfg_wdata;
                REG_PEAK: peak_reg <= cfg_wdata[15:0];
                REG_BW:   bw_reg   <= cfg_wdata[15:0];
                REG_SIDE: side_reg <= cfg_wdata[15:0];
                REG_BACK: back_reg <= cfg_wdata[15:0];
                default:  ;
            endcase
        end
    end

    // prescaled boresight and pattern check, refreshed every cycle
    logic [31:0]        bs_w   [3];
    logic [31:0]        bmag_w [3];
    logic [31:0]        bmax_w;
    logic [4:0]         bsh_w;
    logic signed [15:0] b_reg  [3];
    logic               bad_reg;

    assign bs_w[0] = bsx_reg;
    assign bs_w[1] = bsy_reg;
    assign bs_w[2] = bsz_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) bmag_w[k] = mag_of(bs_w[k]);
        bmax_w = max3(bmag_w[0], bmag_w[1], bmag_w[2]);
        bsh_w  = shift_of(bmax_w);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            b_reg[k] <= scale_of(bmag_w[k], bs_w[k][VECTOR_WIDTH-1], bsh_w);
        end
        bad_reg <= (bmax_w == '0) || (bw_reg == '0) || (bw_reg > ANGLE_MAX) ||
                   (side_reg > SIDELOBE_MAX) || (back_reg > side_reg);
    end

    // global advance: the pipeline moves unless the output holds an untaken item
    logic pipe_en;
    logic m_valid_reg;
    out_t m_item_reg;

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // control chain, one entry per stage ahead of the output register
    ctl_t ctl_reg [PIPE_DEPTH];

    logic [31:0] look_w [3];
    logic [31:0] lmag_w [3];
    logic [31:0] lmax_w;

    assign look_w[0] = s_item.look_x;
    assign look_w[1] = s_item.look_y;
    assign look_w[2] = s_item.look_z;

    always_comb begin
        for (int k = 0; k < 3; k++) lmag_w[k] = mag_of(look_w[k]);
        lmax_w = max3(lmag_w[0], lmag_w[1], lmag_w[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PIPE_DEPTH; k++) ctl_reg[k] <= '0;
        end else if (pipe_en) begin
            ctl_reg[0].vld  <= s_valid;
            ctl_reg[0].zero <= (lmax_w == '0);
            for (int k = 1; k < PIPE_DEPTH; k++) ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    // stage 1: magnitudes and largest magnitude of the look vector
    logic [31:0] mag1_reg [3];
    logic        neg1_reg [3];
    logic [31:0] max1_reg;

    // stage 2: prescaled look vector
    logic signed [15:0] l2_reg [3];

    // stage 3: component products
    logic signed [31:0] p3_reg [9];

    // stage 4: cross components as magnitudes, dot product
    logic [30:0] c4_reg [3];
    dot_t        dot4_reg;

    // stage 5: squared cross components
    logic [61:0] sq5_reg [3];
    dot_t        dot5_reg;

    // stage 6: squared cross magnitude
    logic [63:0] ss6_reg;
    dot_t        dot6_reg;

    logic signed [31:0] cr_w [3];

    assign cr_w[0] = p3_reg[0] - p3_reg[1];
    assign cr_w[1] = p3_reg[2] - p3_reg[3];
    assign cr_w[2] = p3_reg[4] - p3_reg[5];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                mag1_reg[k] <= lmag_w[k];
                neg1_reg[k] <= look_w[k][VECTOR_WIDTH-1];
            end
            max1_reg <= lmax_w;

            for (int k = 0; k < 3; k++) begin
                l2_reg[k] <= scale_of(mag1_reg[k], neg1_reg[k], shift_of(max1_reg));
            end

            p3_reg[0] <= b_reg[1] * l2_reg[2];
            p3_reg[1] <= b_reg[2] * l2_reg[1];
            p3_reg[2] <= b_reg[2] * l2_reg[0];
            p3_reg[3] <= b_reg[0] * l2_reg[2];
            p3_reg[4] <= b_reg[0] * l2_reg[1];
            p3_reg[5] <= b_reg[1] * l2_reg[0];
            p3_reg[6] <= b_reg[0] * l2_reg[0];
            p3_reg[7] <= b_reg[1] * l2_reg[1];
            p3_reg[8] <= b_reg[2] * l2_reg[2];

            for (int k = 0; k < 3; k++) begin
                c4_reg[k] <= cr_w[k][31] ? 31'(-cr_w[k]) : cr_w[k][30:0];
            end
            dot4_reg <= 33'(p3_reg[6]) + 33'(p3_reg[7]) + 33'(p3_reg[8]);

            for (int k = 0; k < 3; k++) sq5_reg[k] <= c4_reg[k] * c4_reg[k];
            dot5_reg <= dot4_reg;

            ss6_reg  <= 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]);
            dot6_reg <= dot5_reg;
        end
    end

    // cross magnitude
    logic [31:0] cmag_w;
    dot_t        dot_sq_w;

    apg_isqrt u_isqrt (
        .aclk    (aclk),
        .en      (pipe_en),
        .rad     (ss6_reg),
        .dot_in  (dot6_reg),
        .root    (cmag_w),
        .dot_out (dot_sq_w)
    );

    // off-axis angle
    logic [15:0] ang_w;

    apg_cordic u_cordic (
        .aclk  (aclk),
        .en    (pipe_en),
        .dot   (dot_sq_w),
        .cmag  (cmag_w),
        .angle (ang_w)
    );

    // gain stage 1: squares and region flags
    logic [15:0] ang_g1_reg;
    logic [31:0] a2_g1_reg;
    logic [31:0] den_g1_reg;
    logic        main_g1_reg;
    logic        side_g1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ang_g1_reg  <= ang_w;
            a2_g1_reg   <= ang_w * ang_w;
            den_g1_reg  <= bw_reg * bw_reg;
            main_g1_reg <= ({ang_w, 1'b0} <= {1'b0, bw_reg});
            side_g1_reg <= (ang_w < DEG90_Q8);
        end
    end

    // main lobe loss: restoring divide, one quotient bit per stage
    typedef struct packed {
        logic [43:0]           rem;
        logic [31:0]           den;
        logic [DIV_STAGES-1:0] q;
        logic [15:0]           ang;
        logic                  main;
        logic                  side;
    } div_t;

    div_t div_reg [DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            div_reg[0].rem  <= 44'({a2_g1_reg, 11'b0}) + 44'({a2_g1_reg, 10'b0}) +
                               44'(den_g1_reg >> 1);
            div_reg[0].den  <= den_g1_reg;
            div_reg[0].q    <= '0;
            div_reg[0].ang  <= ang_g1_reg;
            div_reg[0].main <= main_g1_reg;
            div_reg[0].side <= side_g1_reg;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        localparam int BIT = DIV_STAGES - k;
        logic [43:0] trial;
        div_t        div_next;
        assign trial = 44'(div_reg[k-1].den) << BIT;
        always_comb begin
            div_next = div_reg[k-1];
            if (div_reg[k-1].rem >= trial) begin
                div_next.rem    = div_reg[k-1].rem - trial;
                div_next.q[BIT] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                div_reg[k] <= div_next;
            end
        end
    end

    // output register
    div_t               dv;
    logic signed [16:0] gain_w;

    assign dv = div_reg[DIV_STAGES];

    always_comb begin
        if (dv.main) begin
            gain_w = 17'(peak_reg) - 17'(dv.q);
        end else if (dv.side) begin
            gain_w = 17'(peak_reg) + 17'(side_reg);
        end else begin
            gain_w = 17'(peak_reg) + 17'(back_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= ctl_reg[PIPE_DEPTH-1].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            if (bad_reg) begin
                m_item_reg.gain_q8        <= '0;
                m_item_reg.off_axis_angle <= '0;
                m_item_reg.status         <= ST_BAD_PATTERN;
            end else if (ctl_reg[PIPE_DEPTH-1].zero) begin
                m_item_reg.gain_q8        <= '0;
                m_item_reg.off_axis_angle <= '0;
                m_item_reg.status         <= ST_ZERO_LOOK;
            end else begin
                m_item_reg.gain_q8        <= gain_w;
                m_item_reg.off_axis_angle <= dv.ang;
                m_item_reg.status         <= ST_OK;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // checks
    `APG_ASSERT_NXT(a_accept_enters, s_valid && s_ready, ctl_reg[0].vld,
        "accepted item lost at entry")
    `APG_ASSERT_NXT(a_stall_freezes, aresetn && !pipe_en, $stable(ctl_reg[0]),
        "front stage moved during stall")
    `APG_ASSERT_IMP(a_error_clear, m_valid && (m_item.status != ST_OK),
        (m_item.gain_q8 == '0) && (m_item.off_axis_angle == '0),
        "error result with nonzero fields")
    `APG_ASSERT_IMP(a_bad_status, m_valid && bad_reg, m_item.status == ST_BAD_PATTERN,
        "invalid pattern not reported")
    `APG_ASSERT_IMP(a_angle_range, m_valid, m_item.off_axis_angle <= ANGLE_MAX,
        "angle out of range")

endmodule

### tb/sv/apg_gain_checker.sv
// result checker for the antenna pattern gain evaluator: predicts gain and angle per item
// and compares them with the block's results; depends on apg_pkg
`timescale 1ns / 1ps

module apg_gain_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  apg_pkg::in_t                  s_item,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  apg_pkg::out_t                 m_item,
    input  logic                          cfg_wr_en,
    input  logic [apg_pkg::REG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]                   cfg_wdata,
    output int                            fail_count,
    output int                            gains_owed
);
    import apg_pkg::*;

    // arctangent of 2^-i, degrees Q16.16
    localparam longint ATAN_DEG [20] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    // local copy of the pattern registers
    logic signed [31:0] bs_x, bs_y, bs_z;
    logic signed [15:0] peak, side, back;
    logic [15:0]        bw;

    out_t gain_queue[$];

    assign gains_owed = gain_queue.size();

    // largest magnitude brought under 32768, truncating towards zero
    function automatic bit scale_vec(input longint c[3], output longint o[3]);
        longint unsigned mag[3];
        longint unsigned m;
        int s;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
            if (mag[i] > m) m = mag[i];
        end
        while ((m >> s) > 32767) s++;
        for (int i = 0; i < 3; i++)
            o[i] = c[i] < 0 ? -longint'(mag[i] >> s) : longint'(mag[i] >> s);
        return m != 0;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // cordic vectoring on (dot, cross magnitude), result degrees Q8.8
    function automatic longint unsigned off_axis_q8(input longint x, input longint y);
        longint z, t, xs, ys;
        longint unsigned q;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 5898240;
        end
        for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_DEG[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_DEG[i];
            end
        end
        if (z < 0) z = 0;
        q = (longint'(z) + 128) >> 8;
        return q > 46080 ? 46080 : q;
    endfunction

    function automatic out_t predict_gain(input in_t it);
        longint bv[3], lv[3], b[3], l[3];
        longint cx, cy, cz, dotp, gain, pk, sd, bk, bwl;
        longint unsigned ss, ang, den, num;
        bit bnz, lnz;
        out_t r;
        bv = '{longint'(bs_x), longint'(bs_y), longint'(bs_z)};
        lv = '{longint'(it.look_x), longint'(it.look_y), longint'(it.look_z)};
        bnz = scale_vec(bv, b);
        lnz = scale_vec(lv, l);
        pk = peak;
        sd = side;
        bk = back;
        bwl = bw;
        gain = 0;
        ang = 0;
        r.status = ST_OK;
        if (!bnz || bwl < 1 || bwl > 46080 || sd > -768 || bk > sd) begin
            r.status = ST_BAD_PATTERN;
        end else if (!lnz) begin
            r.status = ST_ZERO_LOOK;
        end else begin
            cx = b[1] * l[2] - b[2] * l[1];
            cy = b[2] * l[0] - b[0] * l[2];
            cz = b[0] * l[1] - b[1] * l[0];
            dotp = b[0] * l[0] + b[1] * l[1] + b[2] * l[2];
            ss = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
            ang = off_axis_q8(dotp, longint'(floor_sqrt(ss)));
            // main lobe includes its edge, ninety degrees is backlobe
            if (2 * ang <= bwl) begin
                den = bwl * bwl;
                num = 3072 * ang * ang + den / 2;
                gain = pk - longint'(num / den);
            end else if (ang < 23040) begin
                gain = pk + sd;
            end else begin
                gain = pk + bk;
            end
        end
        r.gain_q8 = gain[16:0];
        r.off_axis_angle = ang[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // track registers, predict on input items, compare result items
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            bs_x <= 1; bs_y <= 0; bs_z <= 0;
            peak <= PEAK_RESET; bw <= BW_RESET; side <= SIDE_RESET; back <= BACK_RESET;
            gain_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_idx))
                    REG_BS_X: bs_x <= cfg_wdata;
                    REG_BS_Y: bs_y <= cfg_wdata;
                    REG_BS_Z: bs_z <= cfg_wdata;
                    REG_PEAK: peak <= cfg_wdata[15:0];
                    REG_BW:   bw   <= cfg_wdata[15:0];
                    REG_SIDE: side <= cfg_wdata[15:0];
                    REG_BACK: back <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                gain_queue.insert(gain_queue.size(), predict_gain(s_item));
            if (m_valid && m_ready) begin
                if (gain_queue.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = gain_queue.pop_front();
                    if (m_item.gain_q8 !== want.gain_q8)
                        report_mismatch("gain_q8", m_item.gain_q8, want.gain_q8);
                    if (m_item.off_axis_angle !== want.off_axis_angle)
                        report_mismatch("off_axis_angle", m_item.off_axis_angle,
                                        want.off_axis_angle);
                    if (m_item.status !== want.status)
                        report_mismatch("status", m_item.status, want.status);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

### tb/sv/tb_antenna_pattern_gain_eval.sv
// testbench top for the antenna pattern gain evaluator: clock, reset, configuration phases,
// look vector stimulus and verdict; depends on apg_pkg, apg_gain_checker and the evaluator
`timescale 1ns / 1ps

module tb_antenna_pattern_gain_eval;
    import apg_pkg::*;

    localparam int LATENCY    = 73;
    localparam int IDLE_LIMIT = 4000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_item;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_item;
    logic                 cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_wdata;
    int                   fail_count;
    int                   gains_owed;
    int                   idle_cycles;
    int                   burst_left;
    logic signed [31:0]   cur_bs [3];

    antenna_pattern_gain_eval dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    apg_gain_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .gains_owed(gains_owed)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stall pattern in four modes, redrawn at random as the stall counter runs
    int stall_mode;
    int stall_cnt;
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 128 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (stall_cnt % 4 == 0);
            default: m_ready <= (stall_cnt % 40) > 30;
        endcase
    end

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL antenna_pattern_gain_eval");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stop sending and wait until every accepted item has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (gains_owed != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        if (idx <= REG_BS_Z) cur_bs[idx] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // pattern changes only once the block is empty
    task automatic write_pattern(input logic [31:0] bx, input logic [31:0] by,
                                 input logic [31:0] bz, input logic [15:0] pk,
                                 input logic [15:0] bwv, input logic [15:0] sd,
                                 input logic [15:0] bk);
        drain_results();
        write_reg(REG_BS_X, bx);
        write_reg(REG_BS_Y, by);
        write_reg(REG_BS_Z, bz);
        write_reg(REG_PEAK, {16'h0, pk});
        write_reg(REG_BW,   {16'h0, bwv});
        write_reg(REG_SIDE, {16'h0, sd});
        write_reg(REG_BACK, {16'h0, bk});
        @(posedge aclk);
    endtask

    // drive one look vector; the sender bursts and gaps between items
    task automatic send_look(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        int gap;
        s_valid <= 1'b1;
        s_item  <= '{look_x: x, look_y: y, look_z: z};
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 200) - 100;
            2: return 32'sd0;
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $signed($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    // half of the look vectors near the boresight, so the main lobe is well covered
    task automatic send_random_look();
        int sh;
        logic signed [31:0] v [3];
        sh = $urandom_range(1, 20);
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                for (int i = 0; i < 3; i++)
                    v[i] = (cur_bs[i] >>> sh) + $signed($urandom_range(0, 64)) - 32;
            end
            3: begin
                for (int i = 0; i < 3; i++)
                    v[i] = -(cur_bs[i] >>> sh) + $signed($urandom_range(0, 16)) - 8;
            end
            default: begin
                for (int i = 0; i < 3; i++) v[i] = rand_comp();
            end
        endcase
        send_look(v[0], v[1], v[2]);
    endtask

    function automatic logic [15:0] rand_side();
        return 16'(-768 - $signed($urandom_range(0, 20000)));
    endfunction

    initial begin
        logic [15:0] sd;
        s_valid    = 1'b0;
        s_item     = '0;
        m_ready    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_idx    = '0;
        cfg_wdata  = '0;
        stall_mode = 0;
        stall_cnt  = 0;
        idle_cycles = 0;
        burst_left = 0;
        cur_bs     = '{32'sd1, 32'sd0, 32'sd0};
        aresetn    = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset pattern: axes, opposite, zero look, extremes
        send_look(1, 0, 0);
        send_look(-1, 0, 0);
        send_look(0, 1, 0);
        send_look(0, 0, -5);
        send_look(0, 0, 0);
        send_look(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_look(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_look(32'h8000_0000, 0, 1);
        send_look(1000, 87, 0);
        send_look(1000, 88, 0);
        send_look(1000, 0, 44);
        send_look(-1, -1, -1);
        drain_results();

        // directed, degenerate patterns: status precedence and the limits
        write_pattern(0, 0, 0, 16'h7fff, 16'd2560, -16'sd768, -16'sd768);
        send_look(0, 0, 0);
        send_look(5, 5, 5);
        write_pattern(32'h8000_0000, 32'h7fff_ffff, 0, 16'h8000, 16'd0, -16'sd5120, -16'sd7680);
        send_look(1, 1, 1);
        write_pattern(1, 2, 3, 16'h0100, 16'd46081, -16'sd5120, -16'sd7680);
        send_look(1, 2, 3);
        write_pattern(1, 2, 3, 16'h0100, 16'd2560, -16'sd767, -16'sd7680);
        send_look(1, 2, 3);
        write_pattern(1, 2, 3, 16'h0100, 16'd2560, -16'sd5120, -16'sd5119);
        send_look(1, 2, 3);
        write_pattern(0, 0, 32'h7fff_ffff, 16'h7fff, 16'd46080, -16'sd768, -16'sd768);
        send_look(0, 0, 0);
        send_look(0, 1, 1);
        send_look(0, 1, -1);
        send_look(0, 0, -1);
        write_pattern(0, 32'h8000_0000, 0, 16'h8000, 16'd1, 16'h8000, 16'h8000);
        send_look(0, -1, 0);
        send_look(0, 1000, 0);
        send_look(3, -1000, 0);
        drain_results();

        // random phases, each with a fresh pattern
        for (int p = 0; p < 10; p++) begin
            sd = rand_side();
            write_pattern(rand_comp(), rand_comp(), $urandom_range(0, 1) ? rand_comp() : 7,
                          16'($urandom),
                          ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                              16'($urandom_range(1, 46080)),
                          ($urandom_range(0, 9) == 0) ? 16'($urandom) : sd,
                          16'($signed(sd) - $signed(16'($urandom_range(0, 5000)))));
            for (int n = 0; n < 85; n++) begin
                send_random_look();
                // hold the sender off once until the pipeline is empty
                if (p == 4 && n == 40) begin
                    drain_results();
                end
            end
            drain_results();
        end

        if (fail_count == 0) begin
            $display("PASS antenna_pattern_gain_eval");
        end else begin
            $display("FAIL antenna_pattern_gain_eval");
        end
        $finish;
    end

endmodule
